// ===== rtl/cpt_pkg.sv =====
// Shared types and constants for the capture period tachometer.
`timescale 1ns / 1ps

package cpt_pkg;

  // Default geometry of the capture timer and channel set
  localparam int unsigned CHANNELS_DEF   = 2;
  localparam int unsigned COUNTER_W_DEF  = 16;
  localparam int unsigned OVERFLOW_W_DEF = 16;

  // Fixed field and register widths
  localparam int unsigned CAP_W      = 16;
  localparam int unsigned RATE_W     = 26;
  localparam int unsigned POLE_W     = 5;
  localparam int unsigned EDGE_W     = POLE_W + 1;  // edges per revolution, 2 * poles
  localparam int unsigned SPEED_W    = 32;
  localparam int unsigned NUM_W      = 32;          // rate * 60 always fits here
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0] RATE_RESET     = 26'd6250000;
  localparam logic [POLE_W-1:0] POLE_RESET     = 5'd2;
  localparam logic [MIN_W-1:0]  SEC_PER_MINUTE = 6'd60;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_RATE   = 2'd0,
    REG_MAGNET_POLES = 2'd1
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_CAPTURE = 1'b1
  } op_e;

  // Commands to the per-channel capture state
  typedef struct packed {
    logic tick;
    logic capture;
  } chan_cmd_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/cpt_chan_regs.sv =====
// Per-channel last capture value and saturating overflow counters.
`timescale 1ns / 1ps

module cpt_chan_regs import cpt_pkg::*; #(
  parameter int unsigned CHANNELS       = CHANNELS_DEF,
  parameter int unsigned COUNTER_WIDTH  = COUNTER_W_DEF,
  parameter int unsigned OVERFLOW_WIDTH = OVERFLOW_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chan_cmd_t                 cmd_i,
  input  logic                      ch_i,
  input  logic [COUNTER_WIDTH-1:0]  cap_i,
  output logic [COUNTER_WIDTH-1:0]  last_o,
  output logic [OVERFLOW_WIDTH-1:0] ovf_o
);

  logic [COUNTER_WIDTH-1:0]  last_q [CHANNELS];
  logic [COUNTER_WIDTH-1:0]  last_d [CHANNELS];
  logic [OVERFLOW_WIDTH-1:0] ovf_q  [CHANNELS];
  logic [OVERFLOW_WIDTH-1:0] ovf_d  [CHANNELS];

  // Read port for the addressed channel
  always_comb begin
    last_o = '0;
    ovf_o  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch_i) == i) begin
        last_o = last_q[i];
        ovf_o  = ovf_q[i];
      end
    end
  end

  // Tick bumps every counter up to its ceiling; a capture restarts its channel
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      last_d[i] = last_q[i];
      ovf_d[i]  = ovf_q[i];
      if (cmd_i.tick && (ovf_q[i] != '1)) begin
        ovf_d[i] = ovf_q[i] + OVERFLOW_WIDTH'(1);
      end
      if (cmd_i.capture && (int'(ch_i) == i)) begin
        last_d[i] = cap_i;
        ovf_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= '0;
        ovf_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= last_d[i];
        ovf_q[i]  <= ovf_d[i];
      end
    end
  end

endmodule

// ===== rtl/cpt_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cpt_divider import cpt_pkg::*; #(
  parameter int unsigned DIV_W = COUNTER_W_DEF + OVERFLOW_W_DEF + EDGE_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   numer_i,
  input  logic [DIV_W-1:0]   divisor_i,
  output div_status_t        status_o,
  output logic [NUM_W-1:0]   quotient_o
);

  localparam int unsigned CMP_W  = (DIV_W > NUM_W + 1) ? DIV_W : NUM_W + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [CMP_W-1:0]  trial;
  logic [CMP_W-1:0]  dvs_ext;
  logic [CMP_W-1:0]  diff;
  logic              fits;

  // Shared subtract and compare: next numerator bit joins the partial remainder
  assign trial   = CMP_W'({rem_q, quo_q[NUM_W-1]});
  assign dvs_ext = CMP_W'(dvs_q);
  assign diff    = trial - dvs_ext;
  assign fits    = (trial >= dvs_ext);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = numer_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // partial remainder never exceeds the numerator prefix, so it fits NUM_W
      quo_d  = {quo_q[NUM_W-2:0], fits};
      rem_d  = fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

// ===== rtl/capture_period_tachometer.sv =====
// Top level: input capture tachometer with period measurement and rpm division.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tuser {channel, operation}, tdata capture
//  m_axis    out        m_axis_tvalid/tready         tuser speed_channel, tdata speed_rpm
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// A tick leaves the sequencer idle. A capture passes, before the next input transfer, through
// the scaling state, the shared restoring divider (one quotient bit per step), the hand-over
// of the quotient, the load of the output register (after which the result is valid) and the
// idle state; a capture with no positive period skips the divider and the hand-over.
// s_axis_tready is high only while idle; a waiting result stalls only the load of the next
// one. Reset clears channel state and restores register defaults.
`timescale 1ns / 1ps

module capture_period_tachometer import cpt_pkg::*; #(
  parameter int unsigned CHANNELS       = CHANNELS_DEF,
  parameter int unsigned COUNTER_WIDTH  = COUNTER_W_DEF,
  parameter int unsigned OVERFLOW_WIDTH = OVERFLOW_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // capture_count[15:0], direction_forward[16]
  input  logic [1:0]            s_axis_tuser,   // operation[0], channel[1]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SPEED_W-1:0]    m_axis_tdata,   // speed_rpm[31:0]
  output logic                  m_axis_tuser,   // speed_channel[0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PER_W = OVERFLOW_WIDTH + COUNTER_WIDTH;
  localparam int unsigned DIV_W = PER_W + EDGE_W;

  state_e state_q, state_d;

  logic [RATE_W-1:0] rate_q, rate_d;
  logic [POLE_W-1:0] poles_q, poles_d;

  logic                      accept;
  logic                      ch_ok;
  chan_cmd_t                 chan_cmd;
  logic [COUNTER_WIDTH+CAP_W-1:0] cap_ext;
  logic [COUNTER_WIDTH-1:0]  cap_w;
  logic [COUNTER_WIDTH-1:0]  last_cap;
  logic [OVERFLOW_WIDTH-1:0] ovf_cnt;
  logic [PER_W-1:0]          period_c;
  logic                      period_ok_c;

  logic [PER_W-1:0]          period_q;
  logic                      period_ok_q;
  logic                      ch_q;
  logic                      dir_q;

  logic [POLE_W-1:0]         poles_eff;
  logic [EDGE_W-1:0]         edges;
  logic [DIV_W-1:0]          divisor_c;
  logic [NUM_W-1:0]          numer_c;
  logic                      div_start;
  div_status_t               div_status;
  logic [NUM_W-1:0]          quotient;
  logic [SPEED_W-1:0]        mag;
  logic [SPEED_W-1:0]        speed;
  logic                      out_load;

  logic                      m_valid_q, m_valid_d;
  logic [SPEED_W-1:0]        m_data_q;
  logic                      m_user_q;

  // Input decode
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ch_ok  = (32'(s_axis_tuser[1]) < CHANNELS);
  assign chan_cmd.tick    = accept && (op_e'(s_axis_tuser[0]) == OP_TICK);
  assign chan_cmd.capture = accept && (op_e'(s_axis_tuser[0]) == OP_CAPTURE) && ch_ok;

  // Capture value resized to the counter width
  assign cap_ext = {{COUNTER_WIDTH{1'b0}}, s_axis_tdata[CAP_W-1:0]};
  assign cap_w   = cap_ext[COUNTER_WIDTH-1:0];

  cpt_chan_regs #(
    .CHANNELS      (CHANNELS),
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .OVERFLOW_WIDTH(OVERFLOW_WIDTH)
  ) u_chan_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (chan_cmd),
    .ch_i  (s_axis_tuser[1]),
    .cap_i (cap_w),
    .last_o(last_cap),
    .ovf_o (ovf_cnt)
  );

  // Period = overflows * 2^W + capture - last; positive whenever any overflow seen
  assign period_c    = {ovf_cnt, cap_w} - {{OVERFLOW_WIDTH{1'b0}}, last_cap};
  assign period_ok_c = (ovf_cnt != '0) || (cap_w > last_cap);

  always_ff @(posedge clk_i) begin
    if (chan_cmd.capture) begin
      period_q    <= period_c;
      period_ok_q <= period_ok_c;
      ch_q        <= s_axis_tuser[1];
      dir_q       <= s_axis_tdata[CAP_W];
    end
  end

  // Scaling: numerator = rate * 60, divisor = period * 2 * poles (zero poles counts as one)
  assign poles_eff = (poles_q == '0) ? POLE_W'(1) : poles_q;
  assign edges     = {poles_eff, 1'b0};
  assign divisor_c = DIV_W'(period_q) * DIV_W'(edges);
  assign numer_c   = NUM_W'(rate_q) * NUM_W'(SEC_PER_MINUTE);

  cpt_divider #(
    .DIV_W(DIV_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .numer_i   (numer_c),
    .divisor_i (divisor_c),
    .status_o  (div_status),
    .quotient_o(quotient)
  );

  // Sign and zero handling
  assign mag   = period_ok_q ? SPEED_W'(quotient) : '0;
  assign speed = dir_q ? mag : (SPEED_W'(0) - mag);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (chan_cmd.capture) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = period_ok_q ? ST_DIVIDE : ST_EMIT;
      end
      ST_DIVIDE: begin
        if (div_status.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SCALE:  div_start     = period_ok_q;
      ST_DIVIDE: ;
      ST_EMIT:   out_load      = !m_valid_q || m_axis_tready;
      default:   ;
    endcase
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    rate_d  = rate_q;
    poles_d = poles_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COUNT_RATE:   rate_d  = cfg_data_i[RATE_W-1:0];
        REG_MAGNET_POLES: poles_d = cfg_data_i[POLE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rate_q    <= RATE_RESET;
      poles_q   <= POLE_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rate_q    <= rate_d;
      poles_q   <= poles_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= speed;
      m_user_q <= ch_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
